FILE: sv/lpct_pkg.sv
// Package with shared constants, types and the arctangent table for the point transform.
package lpct_pkg;

  localparam int MaxSamples  = 2048;
  localparam int RangeMinMm  = 20;
  localparam int RangeMaxMm  = 65000;
  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int StepsUsed   = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_ANGLE_START = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_ROT_XX      = 3'd2,
    REG_ROT_XY      = 3'd3,
    REG_ROT_YX      = 3'd4,
    REG_ROT_YY      = 3'd5,
    REG_SHIFT_X     = 3'd6,
    REG_SHIFT_Y     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] angle_start;
    logic signed [31:0] angle_step;
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_yx;
    logic signed [15:0] rot_yy;
    logic signed [20:0] shift_x;
    logic signed [20:0] shift_y;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic                      flip;
    logic [15:0]               range;
    logic [11:0]               idx;
  } cordic_stage_t;

  function automatic logic signed [CordicW-1:0] atan_val(input int i);
    logic signed [CordicW-1:0] r;
    r = '0;
    case (i)
      0:  r = 34'sh20000000;
      1:  r = 34'sh12E4051E;
      2:  r = 34'sh09FB385B;
      3:  r = 34'sh051111D4;
      4:  r = 34'sh028B0D43;
      5:  r = 34'sh0145D7E1;
      6:  r = 34'sh00A2F61E;
      7:  r = 34'sh00517C55;
      8:  r = 34'sh0028BE53;
      9:  r = 34'sh00145F2F;
      10: r = 34'sh000A2F98;
      11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6;
      13: r = 34'sh000145F3;
      14: r = 34'sh0000A2F9;
      15: r = 34'sh0000517C;
      16: r = 34'sh000028BE;
      17: r = 34'sh0000145F;
      18: r = 34'sh00000A2F;
      19: r = 34'sh00000517;
      20: r = 34'sh0000028B;
      21: r = 34'sh00000145;
      22: r = 34'sh000000A2;
      23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/lpct_if.sv
// Valid/ready stream interfaces for samples, points and configuration writes.
interface lpct_sample_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        not_finite;
  logic [11:0] sample_index;
  modport source (output valid, range_mm, not_finite, sample_index, input ready);
  modport sink (input valid, range_mm, not_finite, sample_index, output ready);
endinterface

interface lpct_point_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [21:0] point_x;
  logic signed [21:0] point_y;
  logic [11:0]        point_index;
  modport source (output valid, point_x, point_y, point_index, input ready);
  modport sink (input valid, point_x, point_y, point_index, output ready);
endinterface

interface lpct_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lidar_polar_to_cartesian_transform_top.sv
// Top level of the lidar polar-to-Cartesian point transform.
// A fully pipelined datapath: one sample transaction is accepted every cycle unless the output
// stalls, and its point passes the angle multiply, 16 CORDIC stages, four scaling and transform
// stages and the output register; dropped samples produce no point. The whole pipeline
// advances when the output register is empty or being taken, so a stall on the output holds
// every stage in place.
module lidar_polar_to_cartesian_transform_top (
  input logic          clk,
  input logic          rst_n,
  lpct_sample_if.sink  in_s,
  lpct_point_if.source out_p,
  lpct_cfg_if.sink     cfg_w
);
  lpct_pkg::cfg_regs_t     regs;
  lpct_pkg::cordic_stage_t c_in, c_out;
  logic                    en, keep, a_vld_r, c_vld, x_vld;
  logic [31:0]             prod_r;
  logic [15:0]             a_rng_r;
  logic [11:0]             a_idx_r;
  logic [31:0]             ang;
  logic                    ovld_r;
  logic signed [21:0]      ox, oy;
  logic [11:0]             oi;
  logic signed [21:0]      ox_r, oy_r;
  logic [11:0]             oi_r;

  lpct_cfg_regs u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg_w), .regs(regs));

  assign en = !ovld_r || out_p.ready;
  assign in_s.ready = en;
  assign keep = (32'(in_s.sample_index) < 32'(lpct_pkg::MaxSamples)) && !in_s.not_finite &&
                (in_s.range_mm != 16'd0) &&
                (32'(in_s.range_mm) > 32'(lpct_pkg::RangeMinMm)) &&
                (32'(in_s.range_mm) < 32'(lpct_pkg::RangeMaxMm));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_s.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 32'(regs.angle_step * $signed({1'b0, in_s.sample_index}));
      a_rng_r <= in_s.range_mm;
      a_idx_r <= in_s.sample_index;
    end
  end

  always_comb begin
    ang = regs.angle_start + prod_r;
    c_in.flip = ang[31] ^ ang[30];
    c_in.x = lpct_pkg::CordicGain;
    c_in.y = '0;
    c_in.z = 34'($signed({ang[31] ^ c_in.flip, ang[30:0]}));
    c_in.range = a_rng_r;
    c_in.idx = a_idx_r;
  end

  lpct_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(a_vld_r), .in_data(c_in),
    .out_vld(c_vld), .out_data(c_out)
  );

  lpct_xform u_xform (
    .clk(clk), .rst_n(rst_n), .en(en), .regs(regs), .in_vld(c_vld), .in_data(c_out),
    .out_vld(x_vld), .out_x(ox), .out_y(oy), .out_idx(oi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= ox;
      oy_r <= oy;
      oi_r <= oi;
    end
  end

  assign out_p.valid       = ovld_r;
  assign out_p.point_x     = ox_r;
  assign out_p.point_y     = oy_r;
  assign out_p.point_index = oi_r;
endmodule

FILE: sv/lpct_cfg_regs.sv
// Configuration register file written through the configuration channel.
module lpct_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  lpct_cfg_if.sink          cfg,
  output lpct_pkg::cfg_regs_t regs
);
  lpct_pkg::cfg_regs_t regs_r;

  assign cfg.ready = 1'b1;
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.angle_start <= '0;
      regs_r.angle_step  <= '0;
      regs_r.rot_xx      <= 16'sd16384;
      regs_r.rot_xy      <= '0;
      regs_r.rot_yx      <= '0;
      regs_r.rot_yy      <= 16'sd16384;
      regs_r.shift_x     <= '0;
      regs_r.shift_y     <= '0;
    end else if (cfg.valid) begin
      unique case (lpct_pkg::reg_idx_t'(cfg.index))
        lpct_pkg::REG_ANGLE_START: regs_r.angle_start <= cfg.data;
        lpct_pkg::REG_ANGLE_STEP:  regs_r.angle_step  <= cfg.data;
        lpct_pkg::REG_ROT_XX:      regs_r.rot_xx      <= cfg.data[15:0];
        lpct_pkg::REG_ROT_XY:      regs_r.rot_xy      <= cfg.data[15:0];
        lpct_pkg::REG_ROT_YX:      regs_r.rot_yx      <= cfg.data[15:0];
        lpct_pkg::REG_ROT_YY:      regs_r.rot_yy      <= cfg.data[15:0];
        lpct_pkg::REG_SHIFT_X:     regs_r.shift_x     <= cfg.data[20:0];
        lpct_pkg::REG_SHIFT_Y:     regs_r.shift_y     <= cfg.data[20:0];
        default: ;
      endcase
    end
  end
endmodule

FILE: sv/lpct_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module lpct_cordic (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  lpct_pkg::cordic_stage_t in_data,
  output logic                    out_vld,
  output lpct_pkg::cordic_stage_t out_data
);
  localparam int N = lpct_pkg::StepsUsed;

  lpct_pkg::cordic_stage_t st_r [N+1];
  logic [N:0]              vld_r;

  always_comb begin
    st_r[0]  = in_data;
    vld_r[0] = in_vld;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    lpct_pkg::cordic_stage_t nxt;
    lpct_pkg::cordic_stage_t q_r;
    logic                    v_r;
    always_comb begin
      nxt = st_r[i];
      if (!st_r[i].z[lpct_pkg::CordicW-1]) begin
        nxt.x = st_r[i].x - (st_r[i].y >>> i);
        nxt.y = st_r[i].y + (st_r[i].x >>> i);
        nxt.z = st_r[i].z - lpct_pkg::atan_val(i);
      end else begin
        nxt.x = st_r[i].x + (st_r[i].y >>> i);
        nxt.y = st_r[i].y - (st_r[i].x >>> i);
        nxt.z = st_r[i].z + lpct_pkg::atan_val(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r <= nxt;
      end
    end
    always_comb begin
      st_r[i+1]  = q_r;
      vld_r[i+1] = v_r;
    end
  end

  assign out_vld  = vld_r[N];
  assign out_data = st_r[N];
endmodule

FILE: sv/lpct_xform.sv
// Polar-to-Cartesian scaling and affine (2x2 matrix plus shift) transform stages after the CORDIC.
module lpct_xform (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  lpct_pkg::cfg_regs_t     regs,
  input  logic                    in_vld,
  input  lpct_pkg::cordic_stage_t in_data,
  output logic                    out_vld,
  output logic signed [21:0]      out_x,
  output logic signed [21:0]      out_y,
  output logic [11:0]             out_idx
);
  logic signed [33:0] c_r, s_r;
  logic [15:0]        rng_r;
  logic [11:0]        i1_r, i2_r, i3_r;
  logic               v1_r, v2_r, v3_r;
  logic signed [50:0] pc_nxt, ps_nxt;
  logic signed [34:0] px_r, py_r;
  logic signed [50:0] mxx_r, mxy_r, myx_r, myy_r;
  logic signed [52:0] sx, sy;
  logic signed [21:0] ox_r, oy_r;

  always_comb begin
    pc_nxt = c_r * $signed({1'b0, rng_r}) + 51'sd32768;
    ps_nxt = s_r * $signed({1'b0, rng_r}) + 51'sd32768;
    sx = 53'(mxx_r) + 53'(mxy_r) + 53'sd134217728;
    sy = 53'(myx_r) + 53'(myy_r) + 53'sd134217728;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      out_vld <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= in_data.flip ? -in_data.x : in_data.x;
      s_r   <= in_data.flip ? -in_data.y : in_data.y;
      rng_r <= in_data.range;
      i1_r  <= in_data.idx;
      px_r  <= pc_nxt[50:16];
      py_r  <= ps_nxt[50:16];
      i2_r  <= i1_r;
      mxx_r <= 51'(regs.rot_xx * px_r);
      mxy_r <= 51'(regs.rot_xy * py_r);
      myx_r <= 51'(regs.rot_yx * px_r);
      myy_r <= 51'(regs.rot_yy * py_r);
      i3_r  <= i2_r;
      ox_r  <= 22'(sx[52:28] + 25'(regs.shift_x));
      oy_r  <= 22'(sy[52:28] + 25'(regs.shift_y));
      out_idx <= i3_r;
    end
  end

  assign out_x = ox_r;
  assign out_y = oy_r;
endmodule

FILE: bench/lidar_polar_to_cartesian_transform_top_test.sv
// Testbench for the lidar point transform: drives samples, predicts each point and checks it.
`timescale 1ns / 1ps
module lidar_polar_to_cartesian_transform_top_test;

  typedef struct {
    logic signed [21:0] px;
    logic signed [21:0] py;
    logic [11:0]        pidx;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  point_t expected_points[$];

  logic signed [31:0] m_start = 0, m_step = 0;
  logic signed [15:0] m_rxx = 16384, m_rxy = 0, m_ryx = 0, m_ryy = 16384;
  logic signed [20:0] m_sx = 0, m_sy = 0;

  lpct_sample_if sample_ch (clk);
  lpct_point_if  point_ch (clk);
  lpct_cfg_if    cfg_ch (clk);

  lidar_polar_to_cartesian_transform_top u_top (
    .clk(clk), .rst_n(rst_n), .in_s(sample_ch.sink), .out_p(point_ch.source),
    .cfg_w(cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.range_mm = '0;
    sample_ch.not_finite = 1'b0;
    sample_ch.sample_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = lpct_pkg::REG_ANGLE_START;
    cfg_ch.data = '0;
    point_ch.ready = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void rotate_beam(logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, nx;
    logic flip;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang[31] = ~ang[31];
    x = 652032874;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < lpct_pkg::StepsUsed; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(lpct_pkg::atan_val(i));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(lpct_pkg::atan_val(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void predict_point(logic [15:0] rng, logic nf, logic [11:0] idx);
    logic [31:0] ang;
    longint c, s, bx, by, ox, oy;
    point_t p;
    if (idx >= lpct_pkg::MaxSamples || nf || rng == 0 || rng <= lpct_pkg::RangeMinMm ||
        rng >= lpct_pkg::RangeMaxMm)
      return;
    ang = m_start + m_step * {20'd0, idx};
    rotate_beam(ang, c, s);
    bx = floor_shift(c * longint'(rng) + 32768, 16);
    by = floor_shift(s * longint'(rng) + 32768, 16);
    ox = floor_shift(longint'(m_rxx) * bx + longint'(m_rxy) * by + (64'sd1 <<< 27), 28)
         + longint'(m_sx);
    oy = floor_shift(longint'(m_ryx) * bx + longint'(m_ryy) * by + (64'sd1 <<< 27), 28)
         + longint'(m_sy);
    p.px = ox[21:0];
    p.py = oy[21:0];
    p.pidx = idx;
    expected_points.insert(expected_points.size(), p);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("lidar_polar_to_cartesian_transform_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && point_ch.valid && point_ch.ready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected point x=%0d y=%0d index=%0d", point_ch.point_x,
                   point_ch.point_y, point_ch.point_index);
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (e.px !== point_ch.point_x || e.py !== point_ch.point_y ||
            e.pidx !== point_ch.point_index) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Point mismatch: expected x=%0d y=%0d index=%0d, got x=%0d y=%0d index=%0d",
                     e.px, e.py, e.pidx, point_ch.point_x, point_ch.point_y,
                     point_ch.point_index);
        end
      end
    end
  end

  task automatic send_sample(logic [15:0] rng, logic nf, logic [11:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.range_mm <= rng;
    sample_ch.not_finite <= nf;
    sample_ch.sample_index <= idx;
    do @(posedge clk); while (!sample_ch.ready);
    predict_point(rng, nf, idx);
  endtask

  task automatic write_reg(lpct_pkg::reg_idx_t ri, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ri;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (ri)
      lpct_pkg::REG_ANGLE_START: m_start = val;
      lpct_pkg::REG_ANGLE_STEP:  m_step = val;
      lpct_pkg::REG_ROT_XX:      m_rxx = val[15:0];
      lpct_pkg::REG_ROT_XY:      m_rxy = val[15:0];
      lpct_pkg::REG_ROT_YX:      m_ryx = val[15:0];
      lpct_pkg::REG_ROT_YY:      m_ryy = val[15:0];
      lpct_pkg::REG_SHIFT_X:     m_sx = val[20:0];
      lpct_pkg::REG_SHIFT_Y:     m_sy = val[20:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_directed();
    send_sample(16'd1000, 1'b0, 12'd0);
    send_sample(16'd0, 1'b0, 12'd1);
    send_sample(16'd20, 1'b0, 12'd2);
    send_sample(16'd21, 1'b0, 12'd3);
    send_sample(16'd64999, 1'b0, 12'd2047);
    send_sample(16'd65000, 1'b0, 12'd5);
    send_sample(16'hFFFF, 1'b1, 12'hFFF);
    send_sample(16'd5000, 1'b1, 12'd6);
    send_sample(16'd5000, 1'b0, 12'd2048);
    wait_drained();
    write_reg(lpct_pkg::REG_ANGLE_START, 32'h8000_0000);
    write_reg(lpct_pkg::REG_ANGLE_STEP, 32'h7FFF_FFFF);
    write_reg(lpct_pkg::REG_ROT_XX, 16'h8000);
    write_reg(lpct_pkg::REG_ROT_XY, 16'h7FFF);
    write_reg(lpct_pkg::REG_ROT_YX, 16'h7FFF);
    write_reg(lpct_pkg::REG_ROT_YY, 16'h8000);
    write_reg(lpct_pkg::REG_SHIFT_X, 21'h0F_FFFF);
    write_reg(lpct_pkg::REG_SHIFT_Y, 21'h10_0000);
    for (int i = 0; i < 8; i++) send_sample(16'd64999 - i, 1'b0, 12'(i * 291));
    send_sample(16'd40000, 1'b0, 12'd2047);
    wait_drained();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      write_reg(lpct_pkg::REG_ANGLE_START, $urandom);
      write_reg(lpct_pkg::REG_ANGLE_STEP, ph[0] ? $urandom : $urandom_range(2097152));
      write_reg(lpct_pkg::REG_ROT_XX, $urandom);
      write_reg(lpct_pkg::REG_ROT_XY, $urandom);
      write_reg(lpct_pkg::REG_ROT_YX, $urandom);
      write_reg(lpct_pkg::REG_ROT_YY, $urandom);
      write_reg(lpct_pkg::REG_SHIFT_X, $urandom);
      write_reg(lpct_pkg::REG_SHIFT_Y, $urandom);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(9) < 8)
          send_sample(16'($urandom_range(64999, 21)), 1'b0, 12'($urandom_range(2047)));
        else
          send_sample(16'($urandom), 1'($urandom), 12'($urandom));
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 24;
    recv_stall_pct = 63;
    test_directed();
    test_random(4, 60);
    send_idle_pct = 63;
    recv_stall_pct = 24;
    test_random(4, 60);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(4, 55);
    if (mismatch_count == 0 && expected_points.size() == 0)
      $display("lidar_polar_to_cartesian_transform_top_test OK");
    else
      $display("lidar_polar_to_cartesian_transform_top_test NOT OK");
    $finish;
  end
endmodule

FILE: lidar_polar_to_cartesian_transform_top.f
sv/lpct_pkg.sv
sv/lpct_if.sv
sv/lpct_cfg_regs.sv
sv/lpct_cordic.sv
sv/lpct_xform.sv
sv/lidar_polar_to_cartesian_transform_top.sv
bench/lidar_polar_to_cartesian_transform_top_test.sv
